// File: rtl/eso_pkg.sv
// ----------------------------------------------------------------------------
// eso_pkg: shared types and constants
// Word formats, cell link and register codes for the elevator seek scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package eso_pkg;

	localparam int CYL_W      = 16;
	localparam int SUM_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 2'd0,
		REG_SWEEP_UP = 2'd1,
		REG_START    = 2'd2,
		REG_DISK     = 2'd3
	} cfg_reg_t;

	// algorithm_mode codes
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_LOOK = 1'b1;

	// one request word
	typedef struct packed {
		logic [CYL_W-1:0] request_cylinder;
		logic             is_last_request;
	} eso_in_t;

	// one visit word
	typedef struct packed {
		logic [CYL_W-1:0] visit_cylinder;
		logic [CYL_W-1:0] step_distance;
		logic [SUM_W-1:0] running_total;
		logic             is_end_stop;
		logic             is_last_visit;
	} eso_out_t;

	// what a sorting cell hands to the next one down the row
	typedef struct packed {
		logic             vld;  // cell holds a request
		logic             gt;   // held value moves down on this insert
		logic [CYL_W-1:0] val;
	} eso_link_t;

endpackage

`default_nettype wire

// File: rtl/eso_cell.sv
// ----------------------------------------------------------------------------
// eso_cell: one slot of the insertion-sort row
// Holds one request; on insert it keeps its value, takes the new value, or
// takes the value of the cell above, so the row stays sorted ascending.
// ----------------------------------------------------------------------------
`default_nettype none

module eso_cell (
	input  wire logic                    clk,
	input  wire logic                    ins,
	input  wire logic                    vld,
	input  wire logic [eso_pkg::CYL_W-1:0] din,
	input  wire logic [eso_pkg::CYL_W-1:0] start,
	input  wire eso_pkg::eso_link_t        link_in,
	output eso_pkg::eso_link_t             link_out,
	output logic [eso_pkg::CYL_W-1:0]      val,
	output logic                           lt
);
	import eso_pkg::*;

	logic [CYL_W-1:0] val_q;
	logic             above;

	// an empty cell counts as larger than anything
	assign above    = !vld || (val_q > din);
	assign link_out = '{vld: vld, gt: vld && (val_q > din), val: val_q};
	assign val      = val_q;
	assign lt       = vld && (val_q < start);

	// shift down, take the new word, or hold
	always_ff @(posedge clk) begin
		if (ins) begin
			if (link_in.gt) begin
				val_q <= link_in.val;
			end else if (link_in.vld && above) begin
				val_q <= din;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/elevator_seek_order_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_seek_order_scheduler: SCAN / LOOK service order of a request batch
// Requests sort into a row of cells as they arrive; the last one starts a
// sweep that reads the row outward from the head, one visit a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, in_word          | request words in
//  out     | out_valid, out_stall, out_word       | visit words out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register writes in
//
//  A request word is taken every cycle while loading (insert into the row).
//  After the last request: flag, then split count, then one visit per
//  cycle unless out is stalled; n requests give n visits, plus one in SCAN.
//  in_stall is high from the last request until the final visit is loaded.
//  Reset clears the request count and the registers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_seek_order_scheduler #(
	parameter int REQ_SLOTS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire eso_pkg::eso_in_t             in_word,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output eso_pkg::eso_out_t                 out_word,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [eso_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [eso_pkg::CFG_DATA_W-1:0] cfg_data
);
	import eso_pkg::*;

	localparam int CW = $clog2(REQ_SLOTS + 1);
	localparam int IW = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;

	typedef enum logic [1:0] {ST_LOAD, ST_FLAG, ST_SPLIT, ST_EMIT} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              mode_q, sweep_up_q;
	logic [CYL_W-1:0]  start_q, disk_q;
	logic [REQ_SLOTS-1:0] lt_q;
	logic [CW-1:0]     rem_up_q, rem_dn_q, up_ptr_q, dn_ptr_q;
	logic              end_q, su_q;
	logic [CW:0]       tot_q;
	logic [CYL_W-1:0]  arm_q;
	logic [SUM_W-1:0]  sum_q;
	logic              out_valid_q;
	eso_out_t          out_word_q;

	logic              in_go, ins;
	eso_link_t         link [REQ_SLOTS+1];
	logic [CYL_W-1:0]  cell_val [REQ_SLOTS];
	logic [REQ_SLOTS-1:0] lt_flag;
	logic [CW-1:0]     split;
	logic              sel_up, sel_end;
	logic [IW-1:0]     rd_idx;
	logic [CYL_W-1:0]  visit, seek_len;
	logic [SUM_W-1:0]  sum_nx;
	logic              emit_go, last_visit;

	assign in_stall  = (state_q != ST_LOAD);
	assign in_go     = in_valid && !in_stall;
	assign ins       = in_go && (count_q < CW'(REQ_SLOTS));
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// sorting row; cell i is occupied while i < count
	assign link[0] = '{vld: 1'b1, gt: 1'b0, val: '0};
	for (genvar i = 0; i < REQ_SLOTS; i++) begin : g_cell
		eso_cell u_cell (
			.clk     (clk),
			.ins     (ins),
			.vld     (count_q > CW'(i)),
			.din     (in_word.request_cylinder),
			.start   (start_q),
			.link_in (link[i]),
			.link_out(link[i+1]),
			.val     (cell_val[i]),
			.lt      (lt_flag[i])
		);
	end

	assign split = CW'($countones(lt_q));

	// pick the next visit: sweep side first, then end stop, then far side
	always_comb begin
		sel_up  = 1'b0;
		sel_end = 1'b0;
		if (su_q) begin
			priority if (rem_up_q != '0) sel_up = 1'b1;
			else if (end_q)              sel_end = 1'b1;
			else                         sel_up = 1'b0;
		end else begin
			priority if (rem_dn_q != '0) sel_up = 1'b0;
			else if (end_q)              sel_end = 1'b1;
			else                         sel_up = 1'b1;
		end
	end

	assign rd_idx     = sel_up ? up_ptr_q[IW-1:0] : dn_ptr_q[IW-1:0];
	assign visit      = sel_end ? (su_q ? (disk_q - CYL_W'(1)) : '0) : cell_val[rd_idx];
	assign seek_len   = (visit >= arm_q) ? (visit - arm_q) : (arm_q - visit);
	assign sum_nx     = sum_q + SUM_W'(seek_len);
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign last_visit = (tot_q == (CW+1)'(1));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SCAN;
			sweep_up_q <= 1'b1;
			start_q    <= '0;
			disk_q     <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:     mode_q     <= cfg_data[0];
				REG_SWEEP_UP: sweep_up_q <= cfg_data[0];
				REG_START:    start_q    <= cfg_data;
				REG_DISK:     disk_q     <= cfg_data;
			endcase
		end
	end

	// sequencer: load, flag, split count, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			rem_up_q    <= '0;
			rem_dn_q    <= '0;
			up_ptr_q    <= '0;
			dn_ptr_q    <= '0;
			end_q       <= 1'b0;
			su_q        <= 1'b1;
			tot_q       <= '0;
			arm_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= emit_go;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (ins) count_q <= count_q + CW'(1);
					if (in_go && in_word.is_last_request) state_q <= ST_FLAG;
				end
				ST_FLAG: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					rem_dn_q <= split;
					rem_up_q <= count_q - split;
					up_ptr_q <= split;
					dn_ptr_q <= split - CW'(1);
					end_q    <= (mode_q == MODE_SCAN);
					su_q     <= sweep_up_q;
					tot_q    <= {1'b0, count_q} + (CW+1)'(mode_q == MODE_SCAN);
					arm_q    <= start_q;
					sum_q    <= '0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						arm_q <= visit;
						sum_q <= sum_nx;
						tot_q <= tot_q - (CW+1)'(1);
						if (sel_end) begin
							end_q <= 1'b0;
						end else if (sel_up) begin
							up_ptr_q <= up_ptr_q + CW'(1);
							rem_up_q <= rem_up_q - CW'(1);
						end else begin
							dn_ptr_q <= dn_ptr_q - CW'(1);
							rem_dn_q <= rem_dn_q - CW'(1);
						end
						if (last_visit) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
			endcase
		end
	end

	// below-head flags, taken once the batch is complete
	always_ff @(posedge clk) begin
		if (state_q == ST_FLAG) lt_q <= lt_flag;
	end

	// visit word register
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_word_q <= '{visit_cylinder: visit, step_distance: seek_len,
				running_total: sum_nx, is_end_stop: sel_end,
				is_last_visit: last_visit};
		end
	end

endmodule

`default_nettype wire

// File: rtl/eso_checker.sv
// ----------------------------------------------------------------------------
// eso_checker: port-level checks for the elevator seek scheduler
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eso_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire eso_pkg::eso_in_t             in_word,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire eso_pkg::eso_out_t            out_word
);
	import eso_pkg::*;

	// a stalled visit word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("visit word changed under stall");

	// the last request closes the input until the sweep is out
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_word.is_last_request |=> in_stall)
		else $error("request taken right after last request");

	// a sweep that is not finished keeps the input closed
	a_mid_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.is_last_visit |-> in_stall)
		else $error("request taken in the middle of a sweep");

	// every visit's running total is at least its own step distance
	a_total_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.running_total >= SUM_W'(out_word.step_distance))
		else $error("running total below step distance");

endmodule

bind elevator_seek_order_scheduler eso_checker u_eso_checker (.*);

`default_nettype wire
